@@ hdl/dxt_block_decompressor_unit_assert.svh @@
// assertion macros for the block decoder
`ifndef DXT_BLOCK_DECOMPRESSOR_UNIT_ASSERT_SVH
`define DXT_BLOCK_DECOMPRESSOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define DXT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DXT_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define DXT_ASSERT(lbl, clk, rst_n, prop, msg)
`define DXT_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg)
`endif
`endif

@@ hdl/dxt_pkg.sv @@
package dxt_pkg;

  typedef enum logic [2:0] {
    FMT_DXT1 = 3'd0,
    FMT_DXT2 = 3'd1,
    FMT_DXT3 = 3'd2,
    FMT_DXT4 = 3'd3,
    FMT_DXT5 = 3'd4
  } fmt_e;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FORMAT = 2'd2;

  // per-pixel work carried down the pipe
  typedef struct packed {
    logic [13:0] x;
    logic [13:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic        blend;
    logic        last;
  } pix_t;

  // divide a small value by 3 via reciprocal (v < 768)
  function automatic logic [7:0] div3(input logic [9:0] v);
    logic [21:0] p;
    p = 22'(v) * 22'd1366;
    return p[19:12];
  endfunction

  // divide by 7 (v < 1792) and by 5 (v < 1280)
  function automatic logic [7:0] div7(input logic [10:0] v);
    logic [24:0] p;
    p = 25'(v) * 25'd9363;
    return p[23:16];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] v);
    logic [24:0] p;
    p = 25'(v) * 25'd13108;
    return p[23:16];
  endfunction

endpackage

@@ hdl/dxt_block_decompressor_unit.sv @@
// DXT1..DXT5 block decoder. A block request is taken when start is high and
// busy is low; the block then issues one pixel a cycle in raster order,
// clipped to the image (busy is high for every pixel slot but the last, so
// the next request can be taken at the edge that ends the last slot). Each
// pixel appears on the result ports for a single cycle with valid_o high,
// after the pixel select register, the delay line and the output register; the
// receiver cannot stall. last_of_block_o marks the final pixel issued for a block.
// Configuration writes apply to blocks taken after the write.
module dxt_block_decompressor_unit import dxt_pkg::*; #(
  parameter int MAX_DIM = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i,
  input  logic [11:0] block_col_i,
  input  logic [11:0] block_row_i,
  input  logic [63:0] color_block_i,
  input  logic [63:0] alpha_block_i,
  output logic        valid_o,
  output logic [13:0] pixel_x_o,
  output logic [13:0] pixel_y_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic        last_of_block_o
);
  localparam int DimW = $clog2(MAX_DIM + 1);
  localparam int Lat = 8;

  logic [14:0] width_q, height_q;
  logic [2:0]  fmt_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 15'd4;
      height_q <= 15'd4;
      fmt_q <= FMT_DXT1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WIDTH:  width_q <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_FORMAT: fmt_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // stage 1: block capture, palette and clip limits
  logic        act_q;
  logic [3:0]  slot_q;
  logic [15:0] bx_q, by_q;
  logic [63:0] cb_q, ab_q;
  logic [7:0]  pr_q [4], pg_q [4], pb_q [4], pa_q [4];
  logic [7:0]  apal_q [8];
  logic [16:0] w_q, h_q;
  logic [2:0]  mode_q;
  logic [15:0] keep_q;

  logic [7:0] r0, g0, b0, r1, g1, b1, a0, a1;
  logic [16:0] w_d, h_d;
  logic [15:0] bx_d, by_d, keep_d;
  logic        c4;
  always_comb begin
    r0 = {color_block_i[15:11], 3'd0};
    g0 = {color_block_i[10:5], 2'd0};
    b0 = {color_block_i[4:0], 3'd0};
    r1 = {color_block_i[31:27], 3'd0};
    g1 = {color_block_i[26:21], 2'd0};
    b1 = {color_block_i[20:16], 3'd0};
    a0 = alpha_block_i[7:0];
    a1 = alpha_block_i[15:8];
    c4 = color_block_i[15:0] > color_block_i[31:16];
    w_d = ({2'b0, width_q} > 17'(MAX_DIM)) ? 17'(MAX_DIM) : {2'b0, width_q};
    h_d = ({2'b0, height_q} > 17'(MAX_DIM)) ? 17'(MAX_DIM) : {2'b0, height_q};
    bx_d = {2'b0, block_col_i, 2'b0};
    by_d = {2'b0, block_row_i, 2'b0};
    for (int p = 0; p < 16; p++) begin
      keep_d[p] = (17'(bx_d) + 17'(p % 4) < w_d) && (17'(by_d) + 17'(p / 4) < h_d);
    end
  end

  // free again while the last slot is walked
  assign busy = act_q && (slot_q != 4'd15);
  logic take;
  assign take = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      slot_q <= '0;
    end else if (take) begin
      act_q <= 1'b1;
      slot_q <= '0;
    end else if (act_q) begin
      slot_q <= slot_q + 4'd1;
      if (slot_q == 4'd15) act_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      bx_q <= bx_d;
      by_q <= by_d;
      cb_q <= color_block_i;
      ab_q <= alpha_block_i;
      w_q <= w_d;
      h_q <= h_d;
      mode_q <= fmt_q;
      keep_q <= keep_d;
      pr_q[0] <= r0; pg_q[0] <= g0; pb_q[0] <= b0; pa_q[0] <= 8'd255;
      pr_q[1] <= r1; pg_q[1] <= g1; pb_q[1] <= b1; pa_q[1] <= 8'd255;
      if (c4) begin
        pr_q[2] <= div3(10'(r0) * 10'd2 + 10'(r1));
        pg_q[2] <= div3(10'(g0) * 10'd2 + 10'(g1));
        pb_q[2] <= div3(10'(b0) * 10'd2 + 10'(b1));
        pr_q[3] <= div3(10'(r0) + 10'(r1) * 10'd2);
        pg_q[3] <= div3(10'(g0) + 10'(g1) * 10'd2);
        pb_q[3] <= div3(10'(b0) + 10'(b1) * 10'd2);
        pa_q[2] <= 8'd255; pa_q[3] <= 8'd255;
      end else begin
        pr_q[2] <= 8'((9'(r0) + 9'(r1)) >> 1);
        pg_q[2] <= 8'((9'(g0) + 9'(g1)) >> 1);
        pb_q[2] <= 8'((9'(b0) + 9'(b1)) >> 1);
        pa_q[2] <= 8'd255;
        pr_q[3] <= '0; pg_q[3] <= '0; pb_q[3] <= '0; pa_q[3] <= '0;
      end
      apal_q[0] <= a0;
      apal_q[1] <= a1;
      for (int k = 1; k <= 6; k++) begin
        if (a0 > a1)
          apal_q[k+1] <= div7(11'(a0) * 11'(7 - k) + 11'(a1) * 11'(k));
        else if (k <= 4)
          apal_q[k+1] <= div5(11'(a0) * 11'(5 - k) + 11'(a1) * 11'(k));
        else
          apal_q[k+1] <= (k == 5) ? 8'd0 : 8'd255;
      end
    end
  end

  // stage 2: pixel select for the current slot
  logic        s2_v_q;
  pix_t        s2_q;
  logic [1:0]  ci;
  logic [3:0]  nib;
  logic [2:0]  ai;
  logic        more;
  logic [15:0] later;
  pix_t        s2_d;
  always_comb begin
    ci = cb_q[32 + 2*slot_q +: 2];
    nib = ab_q[4*slot_q +: 4];
    ai = ab_q[16 + 3*slot_q +: 3];
    later = keep_q & ~((16'd2 << slot_q) - 16'd1);
    more = later != 16'd0;
    s2_d.x = 14'(bx_q + 16'(slot_q[1:0]));
    s2_d.y = 14'(by_q + 16'(slot_q[3:2]));
    s2_d.r = pr_q[ci];
    s2_d.g = pg_q[ci];
    s2_d.b = pb_q[ci];
    s2_d.blend = (mode_q == FMT_DXT2) || (mode_q == FMT_DXT4);
    if (mode_q == FMT_DXT1) s2_d.a = pa_q[ci];
    else if (mode_q == FMT_DXT2 || mode_q == FMT_DXT3) s2_d.a = {nib, nib};
    else s2_d.a = apal_q[ai];
    s2_d.last = !more;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else s2_v_q <= act_q && keep_q[slot_q];
  end
  always_ff @(posedge clk_i) s2_q <= s2_d;

  // stages 3..: un-premultiply pipe with matching delay line
  logic [7:0] ur, ug, ub;
  dxt_unpremul u_r (.clk_i, .en_i(1'b1), .c_i(s2_q.r), .a_i(s2_q.a), .q_o(ur));
  dxt_unpremul u_g (.clk_i, .en_i(1'b1), .c_i(s2_q.g), .a_i(s2_q.a), .q_o(ug));
  dxt_unpremul u_b (.clk_i, .en_i(1'b1), .c_i(s2_q.b), .a_i(s2_q.a), .q_o(ub));

  logic [Lat:0] v_q;
  pix_t         d_q [Lat+1];
  assign v_q[0] = s2_v_q;
  assign d_q[0] = s2_q;
  for (genvar s = 0; s < Lat; s++) begin : g_dl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[s+1] <= 1'b0;
      else v_q[s+1] <= v_q[s];
    end
    always_ff @(posedge clk_i) d_q[s+1] <= d_q[s];
  end

  // output register
  logic vo_q;
  pix_t o_q;
  pix_t o_d;
  always_comb begin
    o_d = d_q[Lat];
    if (d_q[Lat].blend) begin
      o_d.r = ur;
      o_d.g = ug;
      o_d.b = ub;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else vo_q <= v_q[Lat];
  end
  always_ff @(posedge clk_i) o_q <= o_d;

  assign valid_o = vo_q;
  assign pixel_x_o = o_q.x;
  assign pixel_y_o = o_q.y;
  assign red_o = o_q.r;
  assign green_o = o_q.g;
  assign blue_o = o_q.b;
  assign alpha_o = o_q.a;
  assign last_of_block_o = o_q.last;

  logic unused;
  assign unused = ^{w_q, h_q, DimW[0]};

`include "dxt_block_decompressor_unit_assert.svh"
  `DXT_ASSERT(a_busy16, clk_i, rst_ni, take |=> busy, "block request not held busy")
  `DXT_ASSERT_NEXT(a_last, clk_i, rst_ni, act_q && slot_q == 4'd15 && !take, !act_q, "busy overrun")
  `DXT_ASSERT(a_nostart, clk_i, rst_ni, !(take && act_q && slot_q != 4'd15), "request taken while busy")
endmodule

@@ hdl/dxt_unpremul.sv @@
// un-premultiply one channel, c*255/a saturated, restoring division over 8 stages
module dxt_unpremul import dxt_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [7:0] c_i,
  input  logic [7:0] a_i,
  output logic [7:0] q_o
);
  localparam int Steps = 8;
  // each stage resolves two quotient bits of a 16-bit dividend
  logic [15:0] num_q [Steps+1];
  logic [8:0]  rem_q [Steps+1];
  logic [15:0] quo_q [Steps+1];
  logic [7:0]  den_q [Steps+1];

  always_comb begin
    num_q[0] = {c_i, 8'd0} - {8'd0, c_i};
    rem_q[0] = '0;
    quo_q[0] = '0;
    den_q[0] = a_i;
  end

  for (genvar s = 0; s < Steps; s++) begin : g_st
    logic [15:0] n_d, qq_d;
    logic [8:0]  r_d;
    always_comb begin
      logic [9:0] t;
      logic [8:0] rr;
      rr = rem_q[s];
      n_d = num_q[s];
      qq_d = quo_q[s];
      for (int k = 0; k < 2; k++) begin
        t = {rr, n_d[15]};
        n_d = {n_d[14:0], 1'b0};
        if (t >= {2'b0, den_q[s]}) begin
          rr = 9'(t - {2'b0, den_q[s]});
          qq_d = {qq_d[14:0], 1'b1};
        end else begin
          rr = t[8:0];
          qq_d = {qq_d[14:0], 1'b0};
        end
      end
      r_d = rr;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1] <= n_d;
        rem_q[s+1] <= r_d;
        quo_q[s+1] <= qq_d;
        den_q[s+1] <= den_q[s];
      end
    end
  end

  assign q_o = (den_q[Steps] == 8'd0) ? 8'd0 :
               (quo_q[Steps][15:8] != 8'd0) ? 8'd255 : quo_q[Steps][7:0];
endmodule
